@@ rtl/mlfp_pkg.sv @@
// ----------------------------------------------------------------------------
// mlfp_pkg: shared types and constants for the frame parser
// Result codes, register indexes and the result record passed between stages.
// ----------------------------------------------------------------------------
package mlfp_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned HDR_POS_W  = 3;

    // Reset values of the configuration registers
    localparam logic [WORD_W-1:0] MAGIC_RESET   = 32'h0000_0000;
    localparam logic [WORD_W-1:0] MAX_LEN_RESET = 32'h0010_0000;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_TYPE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BAD     = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAGIC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 2'd1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] value;
        logic              last;
    } t_result;

endpackage

@@ rtl/mlfp_if.sv @@
// ----------------------------------------------------------------------------
// mlfp_if: channel interfaces of the frame parser
// Byte input stream, result stream and configuration write channel.
// ----------------------------------------------------------------------------
interface mlfp_byte_if;
    import mlfp_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mlfp_result_if;
    import mlfp_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] value;
    logic              last;

    modport source (output valid, output kind, output value, output last, input ready);
    modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

interface mlfp_cfg_if;
    import mlfp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/magic_length_frame_parser.sv @@
// ----------------------------------------------------------------------------
// magic_length_frame_parser: magic-word, length-prefixed frame deframer
// Parses a received byte stream into type and payload results.
// ----------------------------------------------------------------------------
// Usage:
//   i_rx  : one received byte per transfer. Each frame is a 4-byte magic word,
//           a 32-bit big-endian length, a type byte and length-1 payload bytes.
//   o_res : one result per type or payload byte (kind, value, last); header
//           bytes give nothing, except a bad-frame result on the eighth one.
//   i_cfg : register writes, index 0 magic word, 1 max frame length; other
//           indexes are dropped. Always ready; write only while idle.
// Path: a byte that transfers is held in the input register, then updates the
//   parser state and the result register together.
// Throughput: one byte per cycle while o_res is not held off.
// Reset: registers return to magic 0 and max length 1048576; parser waits
//   for a header. After a bad frame the parser halts and drops bytes until
//   reset.
// Stall: when o_res is held off, the result register keeps its result, the
//   input register fills, and i_rx.ready drops until the result moves on.
// ----------------------------------------------------------------------------
module magic_length_frame_parser
    import mlfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mlfp_byte_if.sink   i_rx,
    mlfp_result_if.source o_res,
    mlfp_cfg_if.sink    i_cfg
);

    logic [WORD_W-1:0] r_magic_word;
    logic [WORD_W-1:0] r_max_frame_len;

    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              core_pop;
    logic              core_emit;
    t_result           core_result;
    logic              out_free;
    t_result           out_result;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_word    <= MAGIC_RESET;
            r_max_frame_len <= MAX_LEN_RESET;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_MAGIC) begin
                r_magic_word <= i_cfg.data;
            end else if (i_cfg.index == REG_MAX_LEN) begin
                r_max_frame_len <= i_cfg.data;
            end
        end
    end

    mlfp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rx.valid),
        .i_byte  (i_rx.rx_byte),
        .o_ready (i_rx.ready),
        .i_pop   (core_pop),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    mlfp_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (in_valid),
        .i_byte          (in_byte),
        .i_out_free      (out_free),
        .i_magic_word    (r_magic_word),
        .i_max_frame_len (r_max_frame_len),
        .o_pop           (core_pop),
        .o_emit          (core_emit),
        .o_result        (core_result)
    );

    mlfp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (core_emit),
        .i_result (core_result),
        .o_free   (out_free),
        .o_valid  (o_res.valid),
        .i_ready  (o_res.ready),
        .o_result (out_result)
    );

    assign o_res.kind  = out_result.kind;
    assign o_res.value = out_result.value;
    assign o_res.last  = out_result.last;

endmodule

@@ rtl/mlfp_in_stage.sv @@
// ----------------------------------------------------------------------------
// mlfp_in_stage: input byte register
// Holds one received byte until the parser core consumes it.
// ----------------------------------------------------------------------------
module mlfp_in_stage
    import mlfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_ready,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_byte
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    // free when empty or draining this cycle
    assign o_ready = !r_valid || i_pop;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

@@ rtl/mlfp_core.sv @@
// ----------------------------------------------------------------------------
// mlfp_core: frame parser state machine
// Tracks the header, checks magic and length, and builds one result per type or payload byte.
// ----------------------------------------------------------------------------
module mlfp_core
    import mlfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_out_free,
    input  logic [WORD_W-1:0] i_magic_word,
    input  logic [WORD_W-1:0] i_max_frame_len,
    output logic              o_pop,
    output logic              o_emit,
    output t_result           o_result
);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_TYPE    = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_HALTED  = 2'd3
    } t_phase;

    localparam logic [HDR_POS_W-1:0] HDR_LAST = HDR_POS_W'(7);

    t_phase                r_phase,   n_phase;
    logic [HDR_POS_W-1:0]  r_hdr_pos, n_hdr_pos;
    logic                  r_magic_ok, n_magic_ok;
    logic [WORD_W-1:0]     r_len,     n_len;
    logic [WORD_W-1:0]     r_remain,  n_remain;

    logic [BYTE_W-1:0]     want_byte;
    logic [WORD_W-1:0]     len_next;
    logic [WORD_W-1:0]     remain_dec;
    logic                  frame_bad;

    assign o_pop = i_valid && i_out_free;

    // expected magic byte, first byte in the top lane
    always_comb begin
        case (r_hdr_pos[1:0])
            2'd0:    want_byte = i_magic_word[31:24];
            2'd1:    want_byte = i_magic_word[23:16];
            2'd2:    want_byte = i_magic_word[15:8];
            default: want_byte = i_magic_word[7:0];
        endcase
    end

    assign len_next   = {r_len[WORD_W-BYTE_W-1:0], i_byte};
    assign remain_dec = r_remain - WORD_W'(1);
    assign frame_bad  = !r_magic_ok || (len_next == '0) || (len_next > i_max_frame_len);

    // next state and result for the byte at the head of the input stage
    always_comb begin
        n_phase    = r_phase;
        n_hdr_pos  = r_hdr_pos;
        n_magic_ok = r_magic_ok;
        n_len      = r_len;
        n_remain   = r_remain;
        o_emit     = 1'b0;
        o_result   = '{kind: KIND_TYPE, value: i_byte, last: 1'b0};
        if (o_pop) begin
            case (r_phase)
                PH_HEADER: begin
                    n_hdr_pos = r_hdr_pos + HDR_POS_W'(1);
                    if (!r_hdr_pos[2]) begin
                        if (i_byte != want_byte) begin
                            n_magic_ok = 1'b0;
                        end
                    end else begin
                        n_len = len_next;
                    end
                    if (r_hdr_pos == HDR_LAST) begin
                        if (frame_bad) begin
                            n_phase  = PH_HALTED;
                            o_emit   = 1'b1;
                            o_result = '{kind: KIND_BAD, value: '0, last: 1'b1};
                        end else begin
                            n_phase  = PH_TYPE;
                            n_remain = len_next - WORD_W'(1);
                        end
                    end
                end
                PH_TYPE: begin
                    o_emit = 1'b1;
                    if (r_remain == '0) begin
                        o_result.last = 1'b1;
                        n_phase       = PH_HEADER;
                        n_hdr_pos     = '0;
                        n_magic_ok    = 1'b1;
                        n_len         = '0;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    o_emit        = 1'b1;
                    o_result.kind = KIND_PAYLOAD;
                    n_remain      = remain_dec;
                    if (remain_dec == '0) begin
                        o_result.last = 1'b1;
                        n_phase       = PH_HEADER;
                        n_hdr_pos     = '0;
                        n_magic_ok    = 1'b1;
                        n_len         = '0;
                    end
                end
                default: begin
                    // halted: bytes are dropped until reset
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_hdr_pos  <= '0;
            r_magic_ok <= 1'b1;
            r_len      <= '0;
            r_remain   <= '0;
        end else begin
            r_phase    <= n_phase;
            r_hdr_pos  <= n_hdr_pos;
            r_magic_ok <= n_magic_ok;
            r_len      <= n_len;
            r_remain   <= n_remain;
        end
    end

    // halt is sticky until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HALTED |=> r_phase == PH_HALTED)
        else $error("parser left the halted state");

    // a bad-frame result only comes with the eighth header byte
    a_bad_on_hdr_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && o_result.kind == KIND_BAD) |-> (r_phase == PH_HEADER && r_hdr_pos == HDR_LAST))
        else $error("bad-frame result outside the header end");

    // payload phase always has at least one byte left
    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_remain != '0)
        else $error("payload phase with nothing remaining");

    // header position only advances inside the header
    a_hdr_pos_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_TYPE || r_phase == PH_PAYLOAD) |-> r_hdr_pos == '0)
        else $error("header position nonzero outside the header");

endmodule

@@ rtl/mlfp_out_stage.sv @@
// ----------------------------------------------------------------------------
// mlfp_out_stage: result register
// Holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module mlfp_out_stage
    import mlfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // free when empty or the held result transfers this cycle
    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule
